// File: hw/rtl/fpa_pkg.sv
`default_nettype none
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    // quotient bits resolved by the divider pipe
    localparam int QW = 33;
    // scaled dividend width: 2*|a|*2^F + |b|
    localparam int NW = FRAC_BITS + 34;

    localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam logic signed [31:0] FI_MAX = MAX32 >>> FRAC_BITS;
    localparam logic signed [31:0] FI_MIN = MIN32 >>> FRAC_BITS;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,  CMD_SUB  = 4'd1,  CMD_MUL  = 4'd2,  CMD_DIV  = 4'd3,
        CMD_EQ   = 4'd4,  CMD_NE   = 4'd5,  CMD_GT   = 4'd6,  CMD_GE   = 4'd7,
        CMD_LT   = 4'd8,  CMD_LE   = 4'd9,  CMD_MAX  = 4'd10, CMD_MIN  = 4'd11,
        CMD_INC  = 4'd12, CMD_DEC  = 4'd13, CMD_FINT = 4'd14, CMD_TINT = 4'd15
    } cmd_t;

    typedef struct packed {
        cmd_t               command;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic               overflow;
        logic               divide_by_zero;
    } out_word_t;

    typedef struct packed {
        logic [32:0]   rem;
        logic [QW-1:0] num;
        logic [32:0]   den;
        logic [QW-1:0] quo;
        logic          pre_ovf;
    } div_t;

    typedef struct packed {
        cmd_t      cmd;
        logic      neg;
        out_word_t res;
        div_t      div;
    } pipe_t;

endpackage
`default_nettype wire

// File: hw/rtl/fixed_point_alu.sv
`default_nettype none
// Signed 32-bit fixed-point ALU, FRAC_BITS fraction bits. A word is taken
// on every clock with start high (busy is always low) and its result comes
// back on response with done high for one cycle, in order, through stages
// A to D, the divider chain and the output register; one word per cycle
// sustained. The divider resolves one quotient bit per pipeline stage for
// QW = 33 bits. All commands travel the same pipe so results never reorder.
// Mul and div round half away from zero and saturate with overflow; divide
// by zero gives 0 with divide_by_zero set. The receiver cannot stall.
module fixed_point_alu (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire fpa_pkg::in_word_t  request,
    output logic                    done,
    output fpa_pkg::out_word_t      response
);
    import fpa_pkg::*;

    localparam int LATENCY = 5 + QW;

    // stage A: input capture
    logic     a_valid_reg;
    in_word_t a_word_reg;

    // stage B: decode, simple ops, divider setup
    logic        b_valid_reg;
    pipe_t       b_pipe_reg, b_pipe_next;
    logic [31:0] b_maga_reg, b_magb_reg, maga, magb;

    // stage C: product
    logic        c_valid_reg;
    pipe_t       c_pipe_reg;
    logic [63:0] c_prod_reg;

    // stage D: multiply round and saturate
    logic        d_valid_reg;
    pipe_t       d_pipe_reg, d_pipe_next;

    // divider chain
    logic  dv_valid [QW+1];
    pipe_t dv_pipe  [QW+1];

    // output
    logic      done_reg;
    out_word_t resp_reg, resp_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            done_reg    <= dv_valid[QW];
        end
    end

    // stage B logic
    logic signed [31:0] a, b;
    logic signed [32:0] sum, dif;
    logic [NW-1:0]      numer;
    always_comb
    begin
        a = a_word_reg.operand_a;
        b = a_word_reg.operand_b;
        sum = {a[31], a} + {b[31], b};
        dif = {a[31], a} - {b[31], b};
        maga = a[31] ? 32'(-a) : a;
        magb = b[31] ? 32'(-b) : b;
        numer = NW'({maga, FRAC_BITS'(0), 1'b0}) + NW'(magb);

        b_pipe_next = '0;
        b_pipe_next.cmd = a_word_reg.command;
        b_pipe_next.neg = a[31] ^ b[31];
        b_pipe_next.div.rem = 33'(numer >> QW);
        b_pipe_next.div.num = numer[QW-1:0];
        b_pipe_next.div.den = {magb, 1'b0};
        b_pipe_next.div.pre_ovf = 33'(numer >> QW) >= {magb, 1'b0};

        case (a_word_reg.command)
            CMD_ADD:
            begin
                b_pipe_next.res.overflow = sum[32] != sum[31];
                b_pipe_next.res.result_value = b_pipe_next.res.overflow ?
                    (sum[32] ? MIN32 : MAX32) : sum[31:0];
            end
            CMD_SUB:
            begin
                b_pipe_next.res.overflow = dif[32] != dif[31];
                b_pipe_next.res.result_value = b_pipe_next.res.overflow ?
                    (dif[32] ? MIN32 : MAX32) : dif[31:0];
            end
            CMD_DIV:   b_pipe_next.res.divide_by_zero = (b == 0);
            CMD_EQ:    b_pipe_next.res.compare_true = (a == b);
            CMD_NE:    b_pipe_next.res.compare_true = (a != b);
            CMD_GT:    b_pipe_next.res.compare_true = (a > b);
            CMD_GE:    b_pipe_next.res.compare_true = (a >= b);
            CMD_LT:    b_pipe_next.res.compare_true = (a < b);
            CMD_LE:    b_pipe_next.res.compare_true = (a <= b);
            CMD_MAX:   b_pipe_next.res.result_value = (a > b) ? a : b;
            CMD_MIN:   b_pipe_next.res.result_value = (a < b) ? a : b;
            CMD_INC:
            begin
                b_pipe_next.res.overflow = (a == MAX32);
                b_pipe_next.res.result_value = (a == MAX32) ? MAX32 : a + 32'sd1;
            end
            CMD_DEC:
            begin
                b_pipe_next.res.overflow = (a == MIN32);
                b_pipe_next.res.result_value = (a == MIN32) ? MIN32 : a - 32'sd1;
            end
            CMD_FINT:
            begin
                b_pipe_next.res.overflow = (a > FI_MAX) || (a < FI_MIN);
                b_pipe_next.res.result_value = (a > FI_MAX) ? MAX32 :
                    (a < FI_MIN) ? MIN32 : (a <<< FRAC_BITS);
            end
            CMD_TINT:  b_pipe_next.res.result_value = a >>> FRAC_BITS;
            default:   b_pipe_next.res = '0;  // mul finished in stage D
        endcase
    end

    // stage D logic: (p + half) >> F, saturate against signed limit
    logic [63:0] rmag, lim;
    logic        movf;
    always_comb
    begin
        rmag = (c_prod_reg + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        lim  = c_pipe_reg.neg ? 64'h8000_0000 : 64'h7fff_ffff;
        movf = rmag > lim;
        d_pipe_next = c_pipe_reg;
        if (c_pipe_reg.cmd == CMD_MUL)
        begin
            d_pipe_next.res.overflow = movf;
            d_pipe_next.res.result_value = movf ?
                (c_pipe_reg.neg ? MIN32 : MAX32) :
                (c_pipe_reg.neg ? 32'(-rmag[31:0]) : rmag[31:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        a_word_reg <= request;
        b_pipe_reg <= b_pipe_next;
        b_maga_reg <= maga;
        b_magb_reg <= magb;
        c_pipe_reg <= b_pipe_reg;
        c_prod_reg <= b_maga_reg * b_magb_reg;
        d_pipe_reg <= d_pipe_next;
        resp_reg   <= resp_next;
    end

    assign dv_valid[0] = d_valid_reg;
    assign dv_pipe[0]  = d_pipe_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        fpa_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[i]),
            .in_pipe   (dv_pipe[i]),
            .out_valid (dv_valid[i+1]),
            .out_pipe  (dv_pipe[i+1])
        );
    end

    // final: divide saturation
    pipe_t       fin;
    logic [32:0] qlim;
    logic        dovf;
    always_comb
    begin
        fin  = dv_pipe[QW];
        qlim = fin.neg ? 33'h0_8000_0000 : 33'h0_7fff_ffff;
        dovf = fin.div.pre_ovf || (fin.div.quo > qlim);
        resp_next = fin.res;
        if (fin.cmd == CMD_DIV && !fin.res.divide_by_zero)
        begin
            resp_next.overflow = dovf;
            resp_next.result_value = dovf ? (fin.neg ? MIN32 : MAX32) :
                (fin.neg ? 32'(-fin.div.quo[31:0]) : fin.div.quo[31:0]);
        end
    end

    assign done     = done_reg;
    assign response = resp_reg;

    // every accepted word answers after a fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing at fixed latency");
    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.divide_by_zero) |->
            (response.result_value == 0 && !response.overflow))
        else $error("divide by zero result not clean");
    a_cmp_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(response.compare_true && (response.overflow ||
            response.divide_by_zero)))
        else $error("compare flag mixed with arithmetic flags");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(d_valid_reg, QW + 1))
        else $error("result without matching word");
endmodule
`default_nettype wire

// File: hw/rtl/fpa_div_step.sv
`default_nettype none
// one restoring-division step, registered
module fpa_div_step (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire fpa_pkg::pipe_t in_pipe,
    output logic               out_valid,
    output fpa_pkg::pipe_t     out_pipe
);
    import fpa_pkg::*;

    logic [33:0] trial;
    logic        ge;
    pipe_t       step_next;
    logic        valid_reg;
    pipe_t       pipe_reg;

    always_comb
    begin
        trial = {in_pipe.div.rem, in_pipe.div.num[QW-1]};
        ge = trial >= {1'b0, in_pipe.div.den};
        step_next = in_pipe;
        step_next.div.rem = ge ? 33'(trial - {1'b0, in_pipe.div.den}) : trial[32:0];
        step_next.div.num = {in_pipe.div.num[QW-2:0], 1'b0};
        step_next.div.quo = {in_pipe.div.quo[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_reg <= step_next;
    end

    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;
endmodule
`default_nettype wire
